@@ src/cmfuv_pkg.sv @@
// Shared constants, face codes and the inter-cell word type for the cube map
// face/UV block. No dependencies; every other file in src imports this.
package cmfuv_pkg;

  // Component and coordinate formats
  localparam int COMP_BITS       = 16;
  localparam int COORD_FRAC_BITS = 15;

  // Derived widths
  localparam int MAG_W   = COMP_BITS;           // |component|, up to 2^(COMP_BITS-1)
  localparam int DIV_W   = COMP_BITS + 1;       // divisor 2M, dividend and remainder
  localparam int QUO_W   = COORD_FRAC_BITS + 2; // integer bit plus COORD_FRAC_BITS+1 fraction
  localparam int COORD_W = COORD_FRAC_BITS + 1; // Q1.15 result
  localparam int FACE_W  = 3;
  localparam int N_CELLS = COORD_FRAC_BITS + 1; // one cell per fraction bit

  localparam logic [QUO_W-1:0] COORD_ONE = QUO_W'(1) << COORD_FRAC_BITS;

  typedef enum logic [FACE_W-1:0] {
    FACE_POS_X = 3'd0,
    FACE_NEG_X = 3'd1,
    FACE_POS_Y = 3'd2,
    FACE_NEG_Y = 3'd3,
    FACE_POS_Z = 3'd4,
    FACE_NEG_Z = 3'd5
  } face_t;

  // Word handed from one division cell to the next
  typedef struct packed {
    logic             valid;
    logic             degen;
    face_t            face;
    logic [DIV_W-1:0] divisor;  // 2M
    logic [DIV_W-1:0] rem_u;
    logic [DIV_W-1:0] rem_v;
    logic [QUO_W-1:0] quo_u;
    logic [QUO_W-1:0] quo_v;
  } cell_t;

endpackage

@@ src/cmfuv_dir_if.sv @@
// Direction channel: three signed components with valid/ready.
// Depends on cmfuv_pkg.
interface cmfuv_dir_if;
  import cmfuv_pkg::*;

  logic                        valid;
  logic                        ready;
  logic signed [COMP_BITS-1:0] dir_x;
  logic signed [COMP_BITS-1:0] dir_y;
  logic signed [COMP_BITS-1:0] dir_z;

  modport source (output valid, dir_x, dir_y, dir_z, input ready);
  modport sink   (input valid, dir_x, dir_y, dir_z, output ready);
endinterface

@@ src/cmfuv_coord_if.sv @@
// Result channel: face number, Q1.15 face coordinates and degenerate flag.
// Depends on cmfuv_pkg.
interface cmfuv_coord_if;
  import cmfuv_pkg::*;

  logic               valid;
  logic               ready;
  logic [FACE_W-1:0]  face_index;
  logic [COORD_W-1:0] u_coord;
  logic [COORD_W-1:0] v_coord;
  logic               degenerate;

  modport source (output valid, face_index, u_coord, v_coord, degenerate, input ready);
  modport sink   (input valid, face_index, u_coord, v_coord, degenerate, output ready);
endinterface

@@ src/cube_map_face_uv_core.sv @@
// Cube map face selection and UV projection, top level.
// Depends on cmfuv_pkg, cmfuv_dir_if, cmfuv_coord_if, cmfuv_select,
// cmfuv_div_cell and cmfuv_round.
//
// Usage:
//   direction : sink channel, one word per direction (dir_x, dir_y, dir_z, Q2.14).
//   face_uv   : source channel, one word per direction (face_index, u_coord,
//               v_coord in Q1.15, degenerate for the zero vector).
//   The pipeline has two front stages, one division cell per fraction bit and
//   one output register.
//   Throughput is one word per cycle while face_uv.ready stays high; the chain
//   of division cells, one quotient bit per cell, sets the depth, and every
//   cell takes a new word each cycle unless its successor is held.
//   Each stage moves on when empty or when its successor moves, so bubbles
//   collapse and a new word is taken while a finished result waits.
//   When the receiver stalls, words pile up behind the output register;
//   direction.ready drops only once every stage is full.
//   Reset (rst, synchronous) empties every stage; no results are pending.
module cube_map_face_uv_core (
  input  logic          clk,
  input  logic          rst,
  cmfuv_dir_if.sink     direction,
  cmfuv_coord_if.source face_uv
);
  import cmfuv_pkg::*;

  cell_t link  [N_CELLS+1];
  logic  rdy   [N_CELLS+1];

  cmfuv_select u_select (
    .clk        (clk),
    .rst        (rst),
    .direction  (direction),
    .ready_down (rdy[0]),
    .head       (link[0])
  );

  // Row of division cells, cell i feeds cell i+1
  for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
    cmfuv_div_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .prev       (link[i]),
      .ready_down (rdy[i+1]),
      .ready_up   (rdy[i]),
      .cur        (link[i+1])
    );
  end

  cmfuv_round u_round (
    .clk      (clk),
    .rst      (rst),
    .tail     (link[N_CELLS]),
    .ready_up (rdy[N_CELLS]),
    .face_uv  (face_uv)
  );

  // Checks
  a_reset_empty: assert property (@(posedge clk) rst |=> !face_uv.valid)
    else $error("result word present after reset");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (face_uv.valid && face_uv.degenerate) |->
      (face_uv.u_coord == '0 && face_uv.v_coord == '0 && face_uv.face_index == FACE_POS_X))
    else $error("degenerate word carries non-zero fields");

  a_coord_range: assert property (@(posedge clk) disable iff (rst)
    face_uv.valid |->
      ({1'b0, face_uv.u_coord} <= COORD_ONE && {1'b0, face_uv.v_coord} <= COORD_ONE))
    else $error("coordinate above 1.0");

  a_face_range: assert property (@(posedge clk) disable iff (rst)
    face_uv.valid |-> (face_uv.face_index <= FACE_NEG_Z))
    else $error("face index out of range");

endmodule

@@ src/cmfuv_select.sv @@
// Front end: magnitudes, major axis and face, projected components, and the
// seed word for the division chain. Two register stages.
// Depends on cmfuv_pkg and cmfuv_dir_if.
module cmfuv_select (
  input  logic                clk,
  input  logic                rst,
  cmfuv_dir_if.sink           direction,
  input  logic                ready_down,
  output cmfuv_pkg::cell_t    head
);
  import cmfuv_pkg::*;

  typedef struct packed {
    logic                        valid;
    logic signed [COMP_BITS-1:0] dx;
    logic signed [COMP_BITS-1:0] dy;
    logic signed [COMP_BITS-1:0] dz;
    logic [MAG_W-1:0]            mx;
    logic [MAG_W-1:0]            my;
    logic [MAG_W-1:0]            mz;
  } mag_t;

  mag_t  s1;
  mag_t  s1_next;
  cell_t head_next;
  logic  ready1;
  logic  ready2;

  logic [MAG_W-1:0]          m_xy;
  logic [MAG_W-1:0]          m;
  logic [1:0]                axis;
  logic                      neg;
  face_t                     face;
  logic signed [COMP_BITS:0] ex;
  logic signed [COMP_BITS:0] ey;
  logic signed [COMP_BITS:0] ez;
  logic signed [COMP_BITS:0] cu;
  logic signed [COMP_BITS:0] cv;
  logic signed [COMP_BITS+1:0] su;
  logic signed [COMP_BITS+1:0] sv;
  logic [DIV_W-1:0]          a_u;
  logic [DIV_W-1:0]          a_v;
  logic [DIV_W-1:0]          dvs;
  logic                      int_u;
  logic                      int_v;

  // Stage advance: a stage takes a word when empty or when its word moves on
  assign ready2          = !head.valid || ready_down;
  assign ready1          = !s1.valid || ready2;
  assign direction.ready = ready1;

  // Stage 1: register components and their magnitudes
  always_comb begin
    s1_next.valid = direction.valid;
    s1_next.dx    = direction.dir_x;
    s1_next.dy    = direction.dir_y;
    s1_next.dz    = direction.dir_z;
    s1_next.mx    = direction.dir_x[COMP_BITS-1] ? MAG_W'(~direction.dir_x + 1'b1)
                                                 : MAG_W'(direction.dir_x);
    s1_next.my    = direction.dir_y[COMP_BITS-1] ? MAG_W'(~direction.dir_y + 1'b1)
                                                 : MAG_W'(direction.dir_y);
    s1_next.mz    = direction.dir_z[COMP_BITS-1] ? MAG_W'(~direction.dir_z + 1'b1)
                                                 : MAG_W'(direction.dir_z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else if (ready1) begin
      s1 <= s1_next;
    end
  end

  // Stage 2: major axis (ties to the lower axis), face, projection, seed
  always_comb begin
    m_xy = (s1.my > s1.mx) ? s1.my : s1.mx;
    axis = (s1.my > s1.mx) ? 2'd1 : 2'd0;
    m    = m_xy;
    if (s1.mz > m_xy) begin
      m    = s1.mz;
      axis = 2'd2;
    end
    unique case (axis)
      2'd0:    neg = s1.dx[COMP_BITS-1];
      2'd1:    neg = s1.dy[COMP_BITS-1];
      default: neg = s1.dz[COMP_BITS-1];
    endcase
    face = face_t'({axis, neg});

    ex = {s1.dx[COMP_BITS-1], s1.dx};
    ey = {s1.dy[COMP_BITS-1], s1.dy};
    ez = {s1.dz[COMP_BITS-1], s1.dz};
    unique case (face)
      FACE_POS_X: begin cu = -ez; cv = ey;  end
      FACE_NEG_X: begin cu = ez;  cv = ey;  end
      FACE_POS_Y: begin cu = ex;  cv = -ez; end
      FACE_NEG_Y: begin cu = ex;  cv = ez;  end
      FACE_POS_Z: begin cu = ex;  cv = ey;  end
      default:    begin cu = -ex; cv = ey;  end
    endcase

    // a = c + M lies in 0..2M
    su  = {cu[COMP_BITS], cu} + $signed({2'b00, m});
    sv  = {cv[COMP_BITS], cv} + $signed({2'b00, m});
    a_u = su[DIV_W-1:0];
    a_v = sv[DIV_W-1:0];
    dvs = {m, 1'b0};

    // integer bit of a/(2M) is set only when a == 2M
    int_u = (a_u == dvs);
    int_v = (a_v == dvs);

    head_next.valid   = s1.valid;
    head_next.degen   = (m == '0);
    head_next.face    = face;
    head_next.divisor = dvs;
    head_next.rem_u   = int_u ? '0 : a_u;
    head_next.rem_v   = int_v ? '0 : a_v;
    head_next.quo_u   = QUO_W'(int_u);
    head_next.quo_v   = QUO_W'(int_v);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head.valid <= 1'b0;
    end else if (ready2) begin
      head <= head_next;
    end
  end

endmodule

@@ src/cmfuv_div_cell.sv @@
// One restoring division cell: yields one fraction bit of a/(2M) for both
// coordinates and passes the word to its neighbour. Depends on cmfuv_pkg.
module cmfuv_div_cell (
  input  logic              clk,
  input  logic              rst,
  input  cmfuv_pkg::cell_t  prev,
  input  logic              ready_down,
  output logic              ready_up,
  output cmfuv_pkg::cell_t  cur
);
  import cmfuv_pkg::*;

  cell_t          nxt;
  logic [DIV_W:0] two_u;
  logic [DIV_W:0] two_v;
  logic [DIV_W:0] dif_u;
  logic [DIV_W:0] dif_v;
  logic           ge_u;
  logic           ge_v;

  assign ready_up = !cur.valid || ready_down;

  // Shift remainder, trial subtract, keep the bit
  always_comb begin
    two_u = {prev.rem_u, 1'b0};
    two_v = {prev.rem_v, 1'b0};
    dif_u = two_u - {1'b0, prev.divisor};
    dif_v = two_v - {1'b0, prev.divisor};
    ge_u  = (two_u >= {1'b0, prev.divisor});
    ge_v  = (two_v >= {1'b0, prev.divisor});

    nxt       = prev;
    nxt.rem_u = ge_u ? dif_u[DIV_W-1:0] : two_u[DIV_W-1:0];
    nxt.rem_v = ge_v ? dif_v[DIV_W-1:0] : two_v[DIV_W-1:0];
    nxt.quo_u = {prev.quo_u[QUO_W-2:0], ge_u};
    nxt.quo_v = {prev.quo_v[QUO_W-2:0], ge_v};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.valid <= 1'b0;
    end else if (ready_up) begin
      cur <= nxt;
    end
  end

endmodule

@@ src/cmfuv_round.sv @@
// Output stage: round the quotient to nearest (ties up), saturate, zero the
// degenerate case, and hold the result word. Depends on cmfuv_pkg, cmfuv_coord_if.
module cmfuv_round (
  input  logic              clk,
  input  logic              rst,
  input  cmfuv_pkg::cell_t  tail,
  output logic              ready_up,
  cmfuv_coord_if.source     face_uv
);
  import cmfuv_pkg::*;

  logic [QUO_W-1:0]   rnd_u;
  logic [QUO_W-1:0]   rnd_v;
  logic [COORD_W-1:0] u_next;
  logic [COORD_W-1:0] v_next;
  logic [FACE_W-1:0]  face_next;

  assign ready_up = !face_uv.valid || face_uv.ready;

  // q = floor((x + 1) / 2) with x = floor(a * 2^(F+1) / 2M)
  always_comb begin
    rnd_u = (tail.quo_u >> 1) + QUO_W'(tail.quo_u[0]);
    rnd_v = (tail.quo_v >> 1) + QUO_W'(tail.quo_v[0]);
    if (rnd_u > COORD_ONE) rnd_u = COORD_ONE;
    if (rnd_v > COORD_ONE) rnd_v = COORD_ONE;
    if (tail.degen) begin
      u_next    = '0;
      v_next    = '0;
      face_next = FACE_POS_X;
    end else begin
      u_next    = rnd_u[COORD_W-1:0];
      v_next    = rnd_v[COORD_W-1:0];
      face_next = tail.face;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      face_uv.valid <= 1'b0;
    end else if (ready_up) begin
      face_uv.valid <= tail.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up) begin
      face_uv.face_index <= face_next;
      face_uv.u_coord    <= u_next;
      face_uv.v_coord    <= v_next;
      face_uv.degenerate <= tail.degen;
    end
  end

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for cube_map_face_uv_core: directed, random, back-pressure
// and streaming direction words, each result checked against a local predictor.
// Depends on cmfuv_pkg, cmfuv_dir_if, cmfuv_coord_if and the block's RTL.
`timescale 1ns / 100ps

module testbench;
  import cmfuv_pkg::*;

  typedef struct {
    face_t              face;
    logic [COORD_W-1:0] u;
    logic [COORD_W-1:0] v;
    logic               degen;
  } face_uv_word_t;

  localparam int COMP_MAX = (1 << (COMP_BITS - 1)) - 1;
  localparam int COMP_MIN = -(1 << (COMP_BITS - 1));

  logic clk = 1'b0;
  logic rst = 1'b1;

  cmfuv_dir_if   direction_ch ();
  cmfuv_coord_if face_uv_ch ();

  cube_map_face_uv_core dut (
    .clk       (clk),
    .rst       (rst),
    .direction (direction_ch),
    .face_uv   (face_uv_ch)
  );

  face_uv_word_t pending_face_uv[$];

  int err_count     = 0;
  int dirs_accepted = 0;
  int words_checked = 0;
  int degen_seen    = 0;
  int input_stalls  = 0;
  int face_hits[6];

  // idling controls, shared by the tests, send_direction and the sink process
  bit src_gaps      = 1'b0;
  bit sink_stalls   = 1'b0;
  int hold_off_len  = 0;

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // (c/M + 1)/2 in Q1.15, nearest with ties up, clamped to 0..1.0
  function automatic logic [COORD_W-1:0] coord_from(longint c, longint m);
    longint one;
    longint q;
    one = longint'(1) << COORD_FRAC_BITS;
    if (c < -m) c = -m;
    if (c > m) c = m;
    q = (((c + m) << COORD_FRAC_BITS) + m) / (2 * m);
    if (q > one) q = one;
    return COORD_W'(q);
  endfunction

  function automatic face_uv_word_t predict_face_uv(logic signed [COMP_BITS-1:0] x,
                                                    logic signed [COMP_BITS-1:0] y,
                                                    logic signed [COMP_BITS-1:0] z);
    longint        d[3];
    longint        mag[3];
    longint        m;
    longint        cu;
    longint        cv;
    int            axis;
    face_uv_word_t w;
    d[0] = x;
    d[1] = y;
    d[2] = z;
    for (int i = 0; i < 3; i++) mag[i] = (d[i] < 0) ? -d[i] : d[i];
    // largest magnitude, lower axis wins a tie
    axis = 0;
    if (mag[1] > mag[axis]) axis = 1;
    if (mag[2] > mag[axis]) axis = 2;
    m = mag[axis];
    if (m == 0) begin
      w.face  = FACE_POS_X;
      w.u     = '0;
      w.v     = '0;
      w.degen = 1'b1;
      return w;
    end
    w.face  = face_t'(FACE_W'(2 * axis + ((d[axis] < 0) ? 1 : 0)));
    w.degen = 1'b0;
    case (w.face)
      FACE_POS_X: begin cu = -d[2]; cv = d[1];  end
      FACE_NEG_X: begin cu = d[2];  cv = d[1];  end
      FACE_POS_Y: begin cu = d[0];  cv = -d[2]; end
      FACE_NEG_Y: begin cu = d[0];  cv = d[2];  end
      FACE_POS_Z: begin cu = d[0];  cv = d[1];  end
      default:    begin cu = -d[0]; cv = d[1];  end
    endcase
    w.u = coord_from(cu, m);
    w.v = coord_from(cv, m);
    return w;
  endfunction

  task automatic report_mismatch(string field, int want, int got);
    err_count++;
    $display("[%0t] MISMATCH %s: expected %0d, got %0d", $realtime, field, want, got);
  endtask

  // Predict on every accepted direction, check every accepted result
  always @(posedge clk) begin
    face_uv_word_t w;
    if (!rst) begin
      if (direction_ch.valid && direction_ch.ready) begin
        pending_face_uv.push_back(predict_face_uv(direction_ch.dir_x, direction_ch.dir_y,
                                                  direction_ch.dir_z));
        dirs_accepted++;
      end
      if (direction_ch.valid && !direction_ch.ready) input_stalls++;
      if (face_uv_ch.valid && face_uv_ch.ready) begin
        if (pending_face_uv.size() == 0) begin
          report_mismatch("result word with none pending, face", -1, face_uv_ch.face_index);
        end else begin
          w = pending_face_uv.pop_front();
          words_checked++;
          if (face_uv_ch.face_index !== w.face)
            report_mismatch("face_index", w.face, face_uv_ch.face_index);
          if (face_uv_ch.u_coord !== w.u)
            report_mismatch("u_coord", w.u, face_uv_ch.u_coord);
          if (face_uv_ch.v_coord !== w.v)
            report_mismatch("v_coord", w.v, face_uv_ch.v_coord);
          if (face_uv_ch.degenerate !== w.degen)
            report_mismatch("degenerate", w.degen, face_uv_ch.degenerate);
          if (w.degen) degen_seen++;
          else face_hits[w.face]++;
        end
      end
    end
  end

  // Result side: random stall bursts, plus a long hold-off on request
  initial begin
    int n;
    face_uv_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        face_uv_ch.ready <= 1'b0;
      end else if (hold_off_len > 0) begin
        face_uv_ch.ready <= 1'b0;
        n = hold_off_len;
        repeat (n) @(posedge clk);
        hold_off_len = 0;
      end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
        face_uv_ch.ready <= 1'b0;
        n = $urandom_range(1, 12);
        repeat (n) @(posedge clk);
      end else begin
        face_uv_ch.ready <= 1'b1;
      end
    end
  end

  // Offer one direction word, optionally after a gap, and wait for acceptance
  task automatic send_direction(int x, int y, int z);
    int n;
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      direction_ch.valid <= 1'b0;
      direction_ch.dir_x <= COMP_BITS'($urandom);
      direction_ch.dir_y <= COMP_BITS'($urandom);
      direction_ch.dir_z <= COMP_BITS'($urandom);
      n = $urandom_range(1, 12);
      repeat (n) @(posedge clk);
    end
    direction_ch.valid <= 1'b1;
    direction_ch.dir_x <= COMP_BITS'(x);
    direction_ch.dir_y <= COMP_BITS'(y);
    direction_ch.dir_z <= COMP_BITS'(z);
    do @(posedge clk); while (!direction_ch.ready);
  endtask

  function automatic int rand_sign(int mag);
    return ($urandom_range(0, 1) != 0) ? -mag : mag;
  endfunction

  // clamp to the representable component range
  function automatic int clamp_comp(int c);
    if (c > COMP_MAX) return COMP_MAX;
    if (c < COMP_MIN) return COMP_MIN;
    return c;
  endfunction

  // Zero vector, every face, ties, extreme components, coordinate edges
  task automatic test_directed();
    send_direction(0, 0, 0);
    send_direction(16384, 100, -200);
    send_direction(-16384, 100, -200);
    send_direction(50, 16384, -300);
    send_direction(50, -16384, -300);
    send_direction(-70, 20, 16384);
    send_direction(-70, 20, -16384);
    send_direction(COMP_MIN, 0, 0);
    send_direction(0, COMP_MIN, 0);
    send_direction(0, 0, COMP_MIN);
    send_direction(COMP_MIN, COMP_MIN, COMP_MIN);
    send_direction(COMP_MAX, COMP_MAX, COMP_MAX);
    send_direction(COMP_MAX, COMP_MIN, COMP_MAX);
    send_direction(-5, 5, 0);
    send_direction(0, -9, 9);
    send_direction(7, 0, -7);
    send_direction(COMP_MAX, COMP_MAX, COMP_MIN);
    send_direction(100, -100, 100);
    send_direction(-100, 100, -100);
    send_direction(1, 0, 0);
    send_direction(0, 0, -1);
    send_direction(3, -1, 1);
    send_direction(COMP_MIN, COMP_MAX, COMP_MIN + 1);
    send_direction(-1, -1, -1);
  endtask

  // Mostly well-formed directions with one clear major axis, plus noise
  task automatic test_random(int count);
    int c[3];
    int axis;
    int m;
    int v;
    for (int i = 0; i < count; i++) begin
      if (i % 150 == 0) begin
        src_gaps    = ($urandom_range(0, 3) != 0);
        sink_stalls = ($urandom_range(0, 3) != 0);
      end
      axis = $urandom_range(0, 2);
      case ($urandom_range(0, 9))
        0, 1: begin
          for (int k = 0; k < 3; k++) c[k] = clamp_comp(int'($signed(16'($urandom))));
        end
        2, 3, 4, 5: begin
          m = $urandom_range(1, 32768);
          c[axis] = clamp_comp(rand_sign(m));
          for (int k = 0; k < 3; k++)
            if (k != axis) c[k] = clamp_comp(int'($urandom_range(0, 2 * m)) - m);
        end
        6: begin
          // two or three equal magnitudes
          m = $urandom_range(0, 32767);
          for (int k = 0; k < 3; k++) c[k] = rand_sign(m);
          if ($urandom_range(0, 1) != 0) c[axis] = int'($urandom_range(0, m)) - m / 2;
        end
        7: begin
          for (int k = 0; k < 3; k++) c[k] = int'($urandom_range(0, 6)) - 3;
        end
        8: begin
          for (int k = 0; k < 3; k++) begin
            case ($urandom_range(0, 5))
              0: v = COMP_MIN;
              1: v = COMP_MIN + 1;
              2: v = -1;
              3: v = 0;
              4: v = 1;
              default: v = COMP_MAX;
            endcase
            c[k] = v;
          end
        end
        default: begin
          // minors at plus or minus the major magnitude: coordinates at 0 and 1.0
          m = $urandom_range(1, 32767);
          for (int k = 0; k < 3; k++) c[k] = rand_sign(m);
        end
      endcase
      send_direction(c[0], c[1], c[2]);
    end
  endtask

  // Long result hold-off while directions keep coming, so the pipe fills
  task automatic test_backpressure();
    src_gaps     = 1'b0;
    sink_stalls  = 1'b0;
    hold_off_len = 100;
    for (int i = 0; i < 60; i++)
      send_direction(clamp_comp(int'($signed(16'($urandom)))),
                     clamp_comp(int'($signed(16'($urandom)))),
                     clamp_comp(int'($signed(16'($urandom)))));
  endtask

  // Back-to-back words with no idling on either side
  task automatic test_streaming(int count);
    src_gaps    = 1'b0;
    sink_stalls = 1'b0;
    for (int i = 0; i < count; i++)
      send_direction(clamp_comp(int'($signed(16'($urandom)))),
                     clamp_comp(int'($signed(16'($urandom)))),
                     clamp_comp(int'($signed(16'($urandom)))));
  endtask

  // Test sequence
  initial begin
    direction_ch.valid <= 1'b0;
    direction_ch.dir_x <= '0;
    direction_ch.dir_y <= '0;
    direction_ch.dir_z <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(1500);
    test_backpressure();
    test_streaming(200);
    direction_ch.valid <= 1'b0;
    while (pending_face_uv.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Covered %0d directions, %0d results checked, %0d degenerate; input held off %0d cycles.",
             dirs_accepted, words_checked, degen_seen, input_stalls);
    $display("Faces +X %0d  -X %0d  +Y %0d  -Y %0d  +Z %0d  -Z %0d, mismatches %0d.",
             face_hits[0], face_hits[1], face_hits[2], face_hits[3], face_hits[4],
             face_hits[5], err_count);
    if (err_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run
  initial begin
    #10_000_000;
    $display("Timed out with %0d results outstanding.", pending_face_uv.size());
    $display("testbench failed");
    $finish;
  end

endmodule
